FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the window rotator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define SWR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swr assertion failed");

// Expression must never hold
`define SWR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("swr assertion failed");

`endif

FILE: hdl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Types, constants and helpers shared by the square window rotator modules.
// ----------------------------------------------------------------------------
package swr_pkg;

    // Matrix geometry and word size
    localparam int MAX_SIDE  = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = 6;
    localparam int RAD_BITS  = 5;
    localparam int SIDE_BITS = 7;
    localparam int CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_BITS = $clog2(CELLS);

    localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(MAX_SIDE);

    // Operation codes
    localparam logic [1:0] FN_WRITE  = 2'd0;
    localparam logic [1:0] FN_ROTATE = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    // Input transaction payload
    typedef struct packed {
        logic [1:0]           func;
        logic [IDX_BITS-1:0]  row;
        logic [IDX_BITS-1:0]  col;
        logic [RAD_BITS-1:0]  radius;
        logic                 counter_clockwise;
        logic [WORD_BITS-1:0] value;
    } t_swr_in;

    // Output transaction payload
    typedef struct packed {
        logic [WORD_BITS-1:0] read_value;
        logic                 status;
    } t_swr_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input item
        logic item_wr;   // single cell write
        logic item_rd;   // single cell read
        logic clr_idx;   // restart window scan
        logic copy_rd;   // copy phase: read cell, write scratch next cycle
        logic move_rd;   // move phase: read scratch, write cell next cycle
        logic res_load;  // load output payload register
    } t_swr_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       cell_ok;
        logic       win_ok;
        logic       last;
    } t_swr_sts;

    // Linear store address of (row, col)
    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [IDX_BITS-1:0] r,
                                                       input logic [IDX_BITS-1:0] c);
        return ADDR_BITS'(r) * ADDR_BITS'(MAX_SIDE) + ADDR_BITS'(c);
    endfunction

endpackage

FILE: hdl/square_window_rotator_top.sv
// Write or rejected item: accept, execute, done; a read adds a read state before done.
// Rotation runs copy, gap, move and flush steps; the one read port of each store
// (cell, scratch) moves one word per cycle in the copy and in the move phase.
// Throughput: one item at a time; the next is accepted the cycle after a result is loaded.
// Reset (i_rst_n low, synchronous) clears control and sets side_in_use to 64; stores keep data.
// ----------------------------------------------------------------------------
// square_window_rotator_top
// Square word matrix with cell write, cell read and in-place 90 degree
// rotation of a square window through a scratch store.
// ----------------------------------------------------------------------------
module square_window_rotator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swr_pkg::SIDE_BITS-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  swr_pkg::t_swr_in              i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output swr_pkg::t_swr_out             o_result
);
    import swr_pkg::*;

    t_swr_cmd cmd;
    t_swr_sts sts;

    // Sequencer
    swr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Stores and address logic
    swr_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

endmodule

FILE: hdl/swr_ram.sv
// ----------------------------------------------------------------------------
// swr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/swr_datapath.sv
// ----------------------------------------------------------------------------
// swr_datapath
// Item registers, range checks, window scan counters, cell and scratch stores.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swr_pkg::SIDE_BITS-1:0] i_cfg_data,
    input  swr_pkg::t_swr_in              i_item,
    input  swr_pkg::t_swr_cmd             i_cmd,
    output swr_pkg::t_swr_sts             o_sts,
    output swr_pkg::t_swr_out             o_result
);
    import swr_pkg::*;

    logic [SIDE_BITS-1:0] r_side;
    t_swr_in              r_item;
    logic [IDX_BITS-1:0]  r_k;
    logic [IDX_BITS-1:0]  r_l;
    logic [IDX_BITS-1:0]  n_k;
    logic [IDX_BITS-1:0]  n_l;
    logic                 r_wr_pend;
    logic                 r_wr_scr;
    logic [ADDR_BITS-1:0] r_wr_addr;
    t_swr_out             r_result;
    t_swr_out             n_result;

    logic [SIDE_BITS-1:0] side_eff;
    logic                 cell_ok;
    logic                 win_ok;
    logic [IDX_BITS-1:0]  top;
    logic [IDX_BITS-1:0]  left;
    logic [IDX_BITS-1:0]  span;
    logic [IDX_BITS-1:0]  src_r;
    logic [IDX_BITS-1:0]  src_c;
    logic [ADDR_BITS-1:0] item_addr;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [ADDR_BITS-1:0] src_addr;
    logic                 last;

    logic                 cell_we;
    logic [ADDR_BITS-1:0] cell_waddr;
    logic [WORD_BITS-1:0] cell_wdata;
    logic                 cell_re;
    logic [ADDR_BITS-1:0] cell_raddr;
    logic [WORD_BITS-1:0] cell_rdata;
    logic                 scr_we;
    logic [WORD_BITS-1:0] scr_rdata;

    // Side register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
        end else if (i_cfg_we) begin
            r_side <= i_cfg_data;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // Range checks against the side in use, clamped to the store size
    always_comb begin
        side_eff = (r_side > SIDE_BITS'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE) : r_side;
        cell_ok  = ({1'b0, r_item.row} < side_eff) && ({1'b0, r_item.col} < side_eff);
        win_ok   = (r_item.row >= IDX_BITS'(r_item.radius))
                && (r_item.col >= IDX_BITS'(r_item.radius))
                && (({1'b0, r_item.row} + SIDE_BITS'(r_item.radius)) < side_eff)
                && (({1'b0, r_item.col} + SIDE_BITS'(r_item.radius)) < side_eff);
    end

    // Window geometry and scan addresses
    always_comb begin
        top   = r_item.row - IDX_BITS'(r_item.radius);
        left  = r_item.col - IDX_BITS'(r_item.radius);
        span  = {r_item.radius, 1'b0};
        if (r_item.counter_clockwise) begin
            src_r = r_l;
            src_c = span - r_k;
        end else begin
            src_r = span - r_l;
            src_c = r_k;
        end
        item_addr = cell_addr(r_item.row, r_item.col);
        dst_addr  = cell_addr(top + r_k, left + r_l);
        src_addr  = cell_addr(top + src_r, left + src_c);
        last      = (r_k == span) && (r_l == span);
    end

    // Row-major window scan counters
    always_comb begin
        n_k = r_k;
        n_l = r_l;
        if (i_cmd.clr_idx) begin
            n_k = '0;
            n_l = '0;
        end else if (i_cmd.copy_rd || i_cmd.move_rd) begin
            if (r_l == span) begin
                n_l = '0;
                n_k = r_k + 1'b1;
            end else begin
                n_l = r_l + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_l <= n_l;
    end

    // Store write follows in the cycle after the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.copy_rd || i_cmd.move_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_scr  <= i_cmd.copy_rd;
        r_wr_addr <= dst_addr;
    end

    // Cell store port muxing
    always_comb begin
        cell_we    = i_cmd.item_wr || (r_wr_pend && !r_wr_scr);
        cell_waddr = i_cmd.item_wr ? item_addr : r_wr_addr;
        cell_wdata = i_cmd.item_wr ? r_item.value : scr_rdata;
        cell_re    = i_cmd.item_rd || i_cmd.copy_rd;
        cell_raddr = i_cmd.item_rd ? item_addr : dst_addr;
        scr_we     = r_wr_pend && r_wr_scr;
    end

    swr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_re    (cell_re),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    swr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CELLS)
    ) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (r_wr_addr),
        .i_wdata (cell_rdata),
        .i_re    (i_cmd.move_rd),
        .i_raddr (src_addr),
        .o_rdata (scr_rdata)
    );

    // Result payload
    always_comb begin
        n_result.read_value = '0;
        n_result.status     = 1'b0;
        case (r_item.func)
            FN_WRITE: begin
                n_result.status = !cell_ok;
            end
            FN_ROTATE: begin
                n_result.status = !win_ok;
            end
            FN_READ: begin
                n_result.status = !cell_ok;
                if (cell_ok) begin
                    n_result.read_value = cell_rdata;
                end
            end
            default: begin
                n_result.status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result <= n_result;
        end
    end

    assign o_result     = r_result;
    assign o_sts.func    = r_item.func;
    assign o_sts.cell_ok = cell_ok;
    assign o_sts.win_ok  = win_ok;
    assign o_sts.last    = last;

    // A single cell write never collides with a pending rotation write
    `SWR_ASSERT_NEVER(a_cell_port_clash, i_clk, i_rst_n, i_cmd.item_wr && r_wr_pend && !r_wr_scr)
    // Scan counters stay inside the window while it is walked
    `SWR_ASSERT_IMP(a_scan_in_window, i_clk, i_rst_n, i_cmd.copy_rd || i_cmd.move_rd, (r_k <= span) && (r_l <= span))

endmodule

FILE: hdl/swr_ctrl.sv
// ----------------------------------------------------------------------------
// swr_ctrl
// Sequencer: accepts an item, runs write, read or the two-phase rotation,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  swr_pkg::t_swr_sts i_sts,
    output swr_pkg::t_swr_cmd o_cmd
);
    import swr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_COPY  = 8'b0000_0100,
        S_GAP   = 8'b0000_1000,
        S_MOVE  = 8'b0001_0000,
        S_FLUSH = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_swr_state;

    t_swr_state r_state;
    t_swr_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_sts.func)
                    FN_WRITE: begin
                        o_cmd.item_wr = i_sts.cell_ok;
                    end
                    FN_ROTATE: begin
                        if (i_sts.win_ok) begin
                            o_cmd.clr_idx = 1'b1;
                            n_state       = S_COPY;
                        end
                    end
                    FN_READ: begin
                        if (i_sts.cell_ok) begin
                            o_cmd.item_rd = 1'b1;
                            n_state       = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_COPY: begin
                o_cmd.copy_rd = 1'b1;
                if (i_sts.last) begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                // last scratch write lands here; restart the scan
                o_cmd.clr_idx = 1'b1;
                n_state       = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move_rd = 1'b1;
                if (i_sts.last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // A result only appears on leaving the done state
    `SWR_ASSERT_IMP(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE))
    // Output register is never overwritten while a result waits
    `SWR_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, o_cmd.res_load && r_out_valid && i_stall)

endmodule
